### rtl/hmhf_pkg.sv
`default_nettype none

package hmhf_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int LIMIT_W          = 16;
    localparam int NUM_SAMPLES      = 7;
    localparam int MODE_W           = 2;
    localparam int COUNT_W          = 8;
    localparam int APB_ADDR_W       = 5;
    localparam int APB_DATA_W       = 32;
    localparam int REG_IDX_W        = 3;
    localparam int M_TDATA_W        = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_TRACK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONFIRM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HOLD    = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_ENTRY_TICKS = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COMMAND     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TILT        = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RATE        = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SPEED       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_POSITION    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TORQUE      = 3'd6;

    typedef struct packed {
        logic [COUNT_W-1:0]    entry_ticks;
        logic [APB_DATA_W-1:0] command_limits;
        logic [APB_DATA_W-1:0] tilt_limits;
        logic [APB_DATA_W-1:0] rate_limits;
        logic [APB_DATA_W-1:0] speed_limits;
        logic [APB_DATA_W-1:0] position_limits;
        logic [APB_DATA_W-1:0] torque_limits;
    } cfg_t;

    typedef struct packed {
        logic may_enter;
        logic must_exit;
    } verdict_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               just_entered;
        logic [COUNT_W-1:0] confirm_level;
    } result_t;

endpackage

`default_nettype wire

### rtl/hmhf_cfg.sv
`default_nettype none

module hmhf_cfg (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [hmhf_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [hmhf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [hmhf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    output hmhf_pkg::cfg_t                           cfg
);

    hmhf_pkg::cfg_t                  cfg_reg;
    logic [hmhf_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                            wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[hmhf_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                hmhf_pkg::REG_ENTRY_TICKS: begin
                    cfg_reg.entry_ticks <= pwdata[hmhf_pkg::COUNT_W-1:0];
                end
                hmhf_pkg::REG_COMMAND:  cfg_reg.command_limits  <= pwdata;
                hmhf_pkg::REG_TILT:     cfg_reg.tilt_limits     <= pwdata;
                hmhf_pkg::REG_RATE:     cfg_reg.rate_limits     <= pwdata;
                hmhf_pkg::REG_SPEED:    cfg_reg.speed_limits    <= pwdata;
                hmhf_pkg::REG_POSITION: cfg_reg.position_limits <= pwdata;
                hmhf_pkg::REG_TORQUE:   cfg_reg.torque_limits   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            hmhf_pkg::REG_ENTRY_TICKS: prdata = hmhf_pkg::APB_DATA_W'(cfg_reg.entry_ticks);
            hmhf_pkg::REG_COMMAND:     prdata = cfg_reg.command_limits;
            hmhf_pkg::REG_TILT:        prdata = cfg_reg.tilt_limits;
            hmhf_pkg::REG_RATE:        prdata = cfg_reg.rate_limits;
            hmhf_pkg::REG_SPEED:       prdata = cfg_reg.speed_limits;
            hmhf_pkg::REG_POSITION:    prdata = cfg_reg.position_limits;
            hmhf_pkg::REG_TORQUE:      prdata = cfg_reg.torque_limits;
            default:                   prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/hmhf_chk.sv
`default_nettype none

module hmhf_chk #(
    parameter int SAMPLE_WIDTH = hmhf_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                               allow,
    input  wire logic [hmhf_pkg::NUM_SAMPLES-1:0][SAMPLE_WIDTH-1:0] samples,
    input  wire hmhf_pkg::cfg_t                                     cfg,
    output hmhf_pkg::verdict_t                                      verdict
);

    localparam int CMP_W = (SAMPLE_WIDTH > hmhf_pkg::LIMIT_W) ? SAMPLE_WIDTH
                                                               : hmhf_pkg::LIMIT_W;
    localparam int LW    = hmhf_pkg::LIMIT_W;

    localparam int S_SPEED = 0;
    localparam int S_TURN  = 1;
    localparam int S_TILT  = 2;
    localparam int S_RATE  = 3;
    localparam int S_VEL   = 4;
    localparam int S_POS   = 5;
    localparam int S_TORQ  = 6;

    logic [CMP_W-1:0] mag [hmhf_pkg::NUM_SAMPLES];

    // exact magnitude: the most negative sample maps to 2^(SAMPLE_WIDTH-1)
    for (genvar g = 0; g < hmhf_pkg::NUM_SAMPLES; g++) begin : g_mag
        logic [SAMPLE_WIDTH-1:0] neg_w;
        assign neg_w  = ~samples[g] + 1'b1;
        assign mag[g] = CMP_W'(samples[g][SAMPLE_WIDTH-1] ? neg_w : samples[g]);
    end

    logic [CMP_W-1:0] speed_thr, turn_thr;
    logic [CMP_W-1:0] tilt_in, tilt_out, rate_in, rate_out, vel_in, vel_out;
    logic [CMP_W-1:0] pos_in, pos_out, torq_in, torq_out;
    logic             pos_on, torq_on, cmd_busy;

    assign speed_thr = CMP_W'(cfg.command_limits[LW-1:0]);
    assign turn_thr  = CMP_W'(cfg.command_limits[2*LW-1:LW]);
    assign tilt_in   = CMP_W'(cfg.tilt_limits[LW-1:0]);
    assign tilt_out  = CMP_W'(cfg.tilt_limits[2*LW-1:LW]);
    assign rate_in   = CMP_W'(cfg.rate_limits[LW-1:0]);
    assign rate_out  = CMP_W'(cfg.rate_limits[2*LW-1:LW]);
    assign vel_in    = CMP_W'(cfg.speed_limits[LW-1:0]);
    assign vel_out   = CMP_W'(cfg.speed_limits[2*LW-1:LW]);
    assign pos_in    = CMP_W'(cfg.position_limits[LW-1:0]);
    assign pos_out   = CMP_W'(cfg.position_limits[2*LW-1:LW]);
    assign torq_in   = CMP_W'(cfg.torque_limits[LW-1:0]);
    assign torq_out  = CMP_W'(cfg.torque_limits[2*LW-1:LW]);

    // a zero enter threshold switches the position or torque check off
    assign pos_on  = |cfg.position_limits[LW-1:0];
    assign torq_on = |cfg.torque_limits[LW-1:0];

    assign cmd_busy = (mag[S_SPEED] >= speed_thr) || (mag[S_TURN] >= turn_thr);

    assign verdict.may_enter = allow && !cmd_busy
                            && (mag[S_TILT] < tilt_in)
                            && (mag[S_RATE] < rate_in)
                            && (mag[S_VEL]  < vel_in)
                            && (!pos_on  || (mag[S_POS]  < pos_in))
                            && (!torq_on || (mag[S_TORQ] < torq_in));

    assign verdict.must_exit = !allow || cmd_busy
                            || (mag[S_TILT] > tilt_out)
                            || (mag[S_RATE] > rate_out)
                            || (mag[S_VEL]  > vel_out)
                            || (pos_on  && (mag[S_POS]  > pos_out))
                            || (torq_on && (mag[S_TORQ] > torq_out));

endmodule

`default_nettype wire

### rtl/hmhf_fsm.sv
`default_nettype none

module hmhf_fsm (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          step,
    input  wire logic [hmhf_pkg::COUNT_W-1:0]  entry_ticks,
    input  wire hmhf_pkg::verdict_t            verdict,
    output hmhf_pkg::result_t                  res
);

    logic [hmhf_pkg::MODE_W-1:0]  mode_reg, mode_next;
    logic [hmhf_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [hmhf_pkg::COUNT_W-1:0] count_up, count_down;
    logic                         entered;

    assign count_up   = (count_reg == hmhf_pkg::COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign count_down = (count_reg == '0) ? count_reg : count_reg - 1'b1;

    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        entered    = 1'b0;
        if (entry_ticks == '0) begin
            mode_next  = hmhf_pkg::MODE_TRACK;
            count_next = '0;
        end else if (mode_reg == hmhf_pkg::MODE_HOLD) begin
            if (verdict.must_exit) begin
                mode_next  = hmhf_pkg::MODE_TRACK;
                count_next = count_down;
            end
        end else if (verdict.may_enter) begin
            count_next = count_up;
            if (count_up >= entry_ticks) begin
                mode_next = hmhf_pkg::MODE_HOLD;
                entered   = 1'b1;
            end else begin
                mode_next = hmhf_pkg::MODE_CONFIRM;
            end
        end else begin
            mode_next  = hmhf_pkg::MODE_TRACK;
            count_next = count_down;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= hmhf_pkg::MODE_TRACK;
            count_reg <= '0;
        end else if (step) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

    assign res.mode          = mode_next;
    assign res.just_entered  = entered;
    assign res.confirm_level = count_next;

    a_disable_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (entry_ticks == '0) |=> (mode_reg == hmhf_pkg::MODE_TRACK) && (count_reg == '0))
        else $error("disabled tick left mode or count set");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (entry_ticks != '0) |=>
            (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 8'd1)
            || (count_reg == $past(count_reg) - 8'd1))
        else $error("confirm count moved by more than one");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(mode_reg) && $stable(count_reg))
        else $error("state changed without an item");

    a_hold_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (entry_ticks != '0) && (mode_reg == hmhf_pkg::MODE_HOLD)
            && !verdict.must_exit |=> (mode_reg == hmhf_pkg::MODE_HOLD))
        else $error("hold left without an exit condition");

    a_enter_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        step && entered |=> (count_reg >= $past(entry_ticks)))
        else $error("hold entered below the confirm threshold");

endmodule

`default_nettype wire

### rtl/hold_mode_hysteresis_fsm.sv
`default_nettype none
// Channel  Dir  Handshake        Payload
// s_       in   s_tvalid/tready  s_tdata: allow, 7 signed samples
// m_       out  m_tvalid/tready  m_tdata: mode, just_entered, confirm_level
// cfg      in   APB write/read   7 registers at byte address 4*i
//
// One item per cycle unless m_ stalls; items go from the input register to the
// result register on m_. Stage one is the input register, stage two the compares,
// mode/count update and result register; the mode and count state closes its loop
// in stage two. aresetn is synchronous, active low: mode to track, count and
// registers to 0. A stalled m_ side holds the result register; s_tready drops only
// while both stages are full and m_tready is low.
module hold_mode_hysteresis_fsm #(
    parameter int SAMPLE_WIDTH = hmhf_pkg::SAMPLE_WIDTH_DEF,
    localparam int S_TDATA_W = ((1 + hmhf_pkg::NUM_SAMPLES * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // lsb up: allow, speed_command, turn_command, tilt_error, tilt_rate,
    // velocity, position_error, half_torque, zero fill
    input  wire logic [S_TDATA_W-1:0]                s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // lsb up: mode[1:0], just_entered, confirm_level[7:0], zero fill
    output logic      [hmhf_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [hmhf_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [hmhf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [hmhf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready
);

    hmhf_pkg::cfg_t     cfg;
    hmhf_pkg::verdict_t verdict;
    hmhf_pkg::result_t  res, out_res_reg;

    logic                                               in_valid_reg;
    logic                                               in_allow_reg;
    logic [hmhf_pkg::NUM_SAMPLES-1:0][SAMPLE_WIDTH-1:0] in_smp_reg, in_smp;
    logic                                               out_valid_reg;
    logic                                               advance;

    hmhf_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    for (genvar g = 0; g < hmhf_pkg::NUM_SAMPLES; g++) begin : g_unpack
        assign in_smp[g] = s_tdata[1 + g*SAMPLE_WIDTH +: SAMPLE_WIDTH];
    end

    // stage two moves when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_allow_reg <= s_tdata[0];
            in_smp_reg   <= in_smp;
        end
    end

    hmhf_chk #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_chk (
        .allow   (in_allow_reg),
        .samples (in_smp_reg),
        .cfg     (cfg),
        .verdict (verdict)
    );

    hmhf_fsm u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .entry_ticks (cfg.entry_ticks),
        .verdict     (verdict),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = hmhf_pkg::M_TDATA_W'({out_res_reg.confirm_level,
                                             out_res_reg.just_entered,
                                             out_res_reg.mode});

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import hmhf_pkg::*;

    localparam int S_W       = 120;
    localparam int STALL_MAX = 3000;

    // sample slots, lsb up after the allow bit; tilt..torque share their index
    // with the register that holds their thresholds
    localparam int SMP_SPEED_CMD = 0;
    localparam int SMP_TURN_CMD  = 1;
    localparam int SMP_TILT      = 2;
    localparam int SMP_RATE      = 3;
    localparam int SMP_VELOCITY  = 4;
    localparam int SMP_POSITION  = 5;
    localparam int SMP_TORQUE    = 6;

    typedef struct packed {
        logic [NUM_SAMPLES-1:0][LIMIT_W-1:0] smp;
        logic                                allow;
    } sample_t;

    class hold_predictor;
        logic [APB_DATA_W-1:0] regs [7];
        logic [MODE_W-1:0]     mode_q;
        logic [COUNT_W-1:0]    level_q;
        result_t               pending_results [$];
        int                    errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            mode_q  = MODE_TRACK;
            level_q = '0;
            errors  = 0;
        endfunction

        function void set_reg(int idx, logic [APB_DATA_W-1:0] v);
            regs[idx] = (idx == REG_ENTRY_TICKS) ? {24'd0, v[7:0]} : v;
        endfunction

        static function logic [16:0] magnitude(logic [15:0] v);
            return v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
        endfunction

        function void note_sample(sample_t s);
            logic [16:0] mag [7];
            logic        busy, enter_ok, leave;
            logic [15:0] lo, hi;
            result_t     r;
            foreach (mag[k]) mag[k] = magnitude(s.smp[k]);
            busy = mag[SMP_SPEED_CMD] >= regs[REG_COMMAND][15:0] ||
                   mag[SMP_TURN_CMD] >= regs[REG_COMMAND][31:16];
            enter_ok = s.allow && !busy;
            leave    = !s.allow || busy;
            for (int k = SMP_TILT; k <= SMP_TORQUE; k++) begin
                lo = regs[k][15:0];
                hi = regs[k][31:16];
                // position and torque drop out while their enter limit is zero
                if (k < SMP_POSITION || lo != 16'd0) begin
                    if (mag[k] >= lo) enter_ok = 1'b0;
                    if (mag[k] > hi) leave = 1'b1;
                end
            end
            r.just_entered = 1'b0;
            if (regs[REG_ENTRY_TICKS][7:0] == 8'd0) begin
                mode_q  = MODE_TRACK;
                level_q = '0;
            end else if (mode_q == MODE_HOLD) begin
                if (leave) begin
                    mode_q = MODE_TRACK;
                    if (level_q != 0) level_q--;
                end
            end else if (enter_ok) begin
                mode_q = MODE_CONFIRM;
                if (level_q != COUNT_MAX) level_q++;
                if (level_q >= regs[REG_ENTRY_TICKS][7:0]) begin
                    mode_q         = MODE_HOLD;
                    r.just_entered = 1'b1;
                end
            end else begin
                if (level_q != 0) level_q--;
                mode_q = MODE_TRACK;
            end
            r.mode          = mode_q;
            r.confirm_level = level_q;
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            result_t want;
            if (pending_results.size() == 0) begin
                $error("unexpected result item %h", data);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (data[1:0] != want.mode) begin
                $error("mode: expected %0d, got %0d", want.mode, data[1:0]);
                errors++;
            end
            if (data[2] != want.just_entered) begin
                $error("just_entered: expected %0d, got %0d", want.just_entered, data[2]);
                errors++;
            end
            if (data[10:3] != want.confirm_level) begin
                $error("confirm_level: expected %0d, got %0d",
                       want.confirm_level, data[10:3]);
                errors++;
            end
            if (data[15:11] != 5'd0) begin
                $error("zero fill: expected 0, got %0h", data[15:11]);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_W-1:0]        s_tdata;   // lsb up: allow, speed/turn cmd, tilt, rate, vel, pos, torque
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;   // lsb up: mode[1:0], just_entered, confirm_level[7:0]
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int            src_idle;
    int            dst_idle;
    int            stall_cycles;
    hold_predictor predict;

    hold_mode_hysteresis_fsm u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= dst_idle);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) predict.note_sample(sample_t'(s_tdata[112:0]));
            if (m_tvalid && m_tready) predict.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_MAX) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    task automatic send_sample(sample_t s);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, s};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // wait for every result, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (predict.pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        predict.set_reg(idx, data);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic load_limits(logic [7:0] ticks, logic [31:0] cmd, logic [31:0] tilt,
                               logic [31:0] rate, logic [31:0] spd, logic [31:0] pos,
                               logic [31:0] trq);
        settle();
        apb_write(REG_ENTRY_TICKS, {24'd0, ticks});
        apb_write(REG_COMMAND, cmd);
        apb_write(REG_TILT, tilt);
        apb_write(REG_RATE, rate);
        apb_write(REG_SPEED, spd);
        apb_write(REG_POSITION, pos);
        apb_write(REG_TORQUE, trq);
    endtask

    function automatic logic [31:0] limit_pair();
        int unsigned lo, hi;
        lo = $urandom_range(64, 4096);
        hi = lo + $urandom_range(0, 4096);
        return {hi[15:0], lo[15:0]};
    endfunction

    // exit limit only: the enter half is zero, so the check is skipped
    function automatic logic [31:0] skipped_pair();
        return {16'($urandom_range(0, 8192)), 16'd0};
    endfunction

    function automatic logic [15:0] pick_below(logic [15:0] lim);
        int unsigned m;
        if (lim == 16'd0) return 16'd0;
        m = $urandom_range(0, lim - 1);
        if (m > 32767) m = 32767;
        return $urandom_range(1) ? 16'(-m) : 16'(m);
    endfunction

    // magnitude between the enter and exit limits: fails entry, keeps hold
    function automatic logic [15:0] pick_band(logic [15:0] lo, logic [15:0] hi);
        int unsigned m;
        m = $urandom_range(lo, hi);
        if (m >= 32768) return 16'h8000;
        return $urandom_range(1) ? 16'(-m) : 16'(m);
    endfunction

    function automatic sample_t quiet_sample();
        sample_t s;
        s.allow = 1'b1;
        s.smp[SMP_SPEED_CMD] = pick_below(predict.regs[REG_COMMAND][15:0]);
        s.smp[SMP_TURN_CMD]  = pick_below(predict.regs[REG_COMMAND][31:16]);
        for (int k = SMP_TILT; k <= SMP_TORQUE; k++) begin
            if (k >= SMP_POSITION && predict.regs[k][15:0] == 16'd0) begin
                s.smp[k] = 16'($urandom);
            end else begin
                s.smp[k] = pick_below(predict.regs[k][15:0]);
            end
        end
        return s;
    endfunction

    task automatic run_phase(int n, int noise, int band);
        sample_t s;
        int      r;
        int      k;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < noise) begin
                s.allow = 1'($urandom_range(1));
                foreach (s.smp[j]) s.smp[j] = 16'($urandom);
            end else begin
                s = quiet_sample();
                if (r < noise + band) begin
                    k = $urandom_range(SMP_TILT, SMP_TORQUE);
                    s.smp[k] = pick_band(predict.regs[k][15:0], predict.regs[k][31:16]);
                end
            end
            send_sample(s);
        end
    endtask

    task automatic directed_run();
        sample_t s;
        load_limits(8'd2, 32'h1000_1000, 32'h0200_0100, 32'h0200_0100,
                    32'h0200_0100, 32'h0200_0100, 32'h0200_0100);
        s = '0;
        s.allow = 1'b1;
        send_sample(s);
        send_sample(s);                            // enter hold
        s.smp[SMP_TILT] = 16'h0200;
        send_sample(s);                            // equal to exit limit: hold
        s.smp[SMP_TILT] = 16'hFDFF;
        send_sample(s);                            // just past exit limit: leave
        s.smp[SMP_TILT] = 16'h0000;
        send_sample(s);
        s.allow = 1'b0;
        send_sample(s);                            // hold not allowed
        s.allow = 1'b1;
        send_sample(s);
        s.smp[SMP_TURN_CMD] = 16'hF000;
        send_sample(s);                            // command at its limit
        s.smp[SMP_TURN_CMD] = 16'h0000;
        send_sample(s);
        s.smp[SMP_TORQUE] = 16'h8000;
        send_sample(s);                            // most negative torque
        s.smp[SMP_TORQUE] = 16'h0000;
        s.smp[SMP_RATE] = 16'h0100;
        send_sample(s);                            // rate equal to enter limit
        s.smp[SMP_VELOCITY] = 16'h7FFF;
        send_sample(s);
        s = '0;
        s.allow = 1'b1;
        s.smp[SMP_SPEED_CMD] = 16'h0FFF;
        send_sample(s);
        send_sample(s);
        s.smp[SMP_POSITION] = 16'h0200;
        send_sample(s);
        s.smp[SMP_VELOCITY] = 16'h0201;
        send_sample(s);
        s.allow = 1'b0;
        foreach (s.smp[j]) s.smp[j] = 16'h7FFF;
        send_sample(s);
        s.allow = 1'b1;
        foreach (s.smp[j]) s.smp[j] = 16'h8000;
        send_sample(s);
        // position and torque checks switched off
        load_limits(8'd2, 32'h1000_1000, 32'h0200_0100, 32'h0200_0100,
                    32'h0200_0100, 32'h0010_0000, 32'h0010_0000);
        s = '0;
        s.allow = 1'b1;
        s.smp[SMP_POSITION] = 16'h8000;
        s.smp[SMP_TORQUE]   = 16'h7FFF;
        send_sample(s);
        send_sample(s);
        send_sample(s);
    endtask

    initial begin
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        aresetn      = 1'b0;
        src_idle     = 0;
        dst_idle     = 0;
        stall_cycles = 0;
        predict      = new();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        src_idle = 23;
        dst_idle = 49;
        directed_run();
        load_limits(8'd1, limit_pair(), limit_pair(), limit_pair(), limit_pair(),
                    limit_pair(), limit_pair());
        run_phase(45, 10, 15);
        load_limits(8'd0, limit_pair(), limit_pair(), limit_pair(), limit_pair(),
                    limit_pair(), limit_pair());
        run_phase(20, 10, 10);
        load_limits(8'd5, limit_pair(), limit_pair(), limit_pair(), limit_pair(),
                    skipped_pair(), skipped_pair());
        run_phase(45, 10, 15);

        src_idle = 49;
        dst_idle = 23;
        // long climb to the top of the count
        load_limits(8'd255, limit_pair(), limit_pair(), limit_pair(), limit_pair(),
                    limit_pair(), limit_pair());
        run_phase(300, 1, 1);
        load_limits(8'd2, '1, '1, '1, '1, '1, '1);
        run_phase(30, 30, 10);

        src_idle = 0;
        dst_idle = 0;
        load_limits(8'd3, '0, '0, '0, '0, '0, '0);
        run_phase(20, 50, 10);
        load_limits(8'($urandom_range(2, 12)), $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
        run_phase(50, 20, 15);
        load_limits(8'd4, limit_pair(), limit_pair(), limit_pair(), limit_pair(),
                    limit_pair(), limit_pair());
        run_phase(40, 10, 15);

        settle();
        if (predict.pending_results.size() != 0) predict.errors++;
        if (predict.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
